[rtl/m3inv_pkg.sv]
// Shared widths and types for the 3x3 fixed-point matrix inverse.
package m3inv_pkg;

  localparam int ELEMENT_WIDTH = 32;
  localparam int FRACTION_BITS = 16;

  localparam int ElemW    = ELEMENT_WIDTH;
  localparam int ProdW    = 2 * ElemW;
  localparam int CofW     = 2 * ElemW + 1;
  localparam int PpW      = 2 * ElemW + 1;
  localparam int DetW     = 3 * ElemW + 3;
  localparam int NumW     = CofW + 2 * FRACTION_BITS;
  localparam int NumHiW   = NumW - ElemW;
  localparam int RemW     = DetW + 1;
  localparam int LaneLat  = ElemW + 2;
  localparam int FrontLat = 5;
  localparam int NumElem  = 9;
  localparam int TdataW   = ((NumElem * ElemW + 7) / 8) * 8;
  localparam int TuserW   = 2;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [CofW-1:0]  cof_t;
  typedef logic signed [PpW-1:0]   pp_t;
  typedef logic signed [DetW-1:0]  det_t;
  typedef logic [DetW-1:0]         dmag_t;

  typedef struct packed {
    logic [ElemW-1:0] q;
    logic             ovf;
  } lane_res_t;

endpackage

[rtl/m3inv_adj.sv]
// Cofactor stage: eighteen products, then the nine adjugate elements.
module m3inv_adj import m3inv_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  elem_t elem_i [NumElem],
  output cof_t  cof_o  [NumElem],
  output elem_t row_o  [3]
);

  prod_t p0_q [NumElem];
  prod_t p1_q [NumElem];
  elem_t row1_q [3];
  cof_t  cof_q [NumElem];
  elem_t row2_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_i
    for (genvar j = 0; j < 3; j++) begin : g_j
      localparam int K  = 3 * i + j;
      localparam int R1 = (j + 1) % 3;
      localparam int R2 = (j + 2) % 3;
      localparam int C1 = (i + 1) % 3;
      localparam int C2 = (i + 2) % 3;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          p0_q[K]  <= elem_i[3*R1+C1] * elem_i[3*R2+C2];
          p1_q[K]  <= elem_i[3*R1+C2] * elem_i[3*R2+C1];
          cof_q[K] <= CofW'(p0_q[K]) - CofW'(p1_q[K]);
        end
      end
    end
  end

  for (genvar m = 0; m < 3; m++) begin : g_row
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        row1_q[m] <= elem_i[m];
        row2_q[m] <= row1_q[m];
      end
    end
  end

  assign cof_o = cof_q;
  assign row_o = row2_q;

endmodule

[rtl/m3inv_det.sv]
// Determinant stage: split products, sum, then magnitude, sign and zero test.
module m3inv_det import m3inv_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  cof_t  cof_i [NumElem],
  input  elem_t row_i [3],
  output cof_t  cof_o [NumElem],
  output dmag_t den_o,
  output logic  den_neg_o,
  output logic  sing_o
);

  pp_t   plo_q [3];
  pp_t   phi_q [3];
  cof_t  cof3_q [NumElem];
  cof_t  cof4_q [NumElem];
  cof_t  cof5_q [NumElem];
  det_t  det_q;
  dmag_t den_q;
  logic  den_neg_q;
  logic  sing_q;
  det_t  det_d;

  for (genvar m = 0; m < 3; m++) begin : g_pp
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        plo_q[m] <= PpW'(row_i[m]) * $signed({1'b0, cof_i[3*m][ElemW-1:0]});
        phi_q[m] <= PpW'(row_i[m]) * PpW'($signed(cof_i[3*m][CofW-1:ElemW]));
      end
    end
  end

  always_comb begin
    det_d = '0;
    for (int m = 0; m < 3; m++) begin
      det_d = det_d + (DetW'(phi_q[m]) <<< ElemW) + DetW'(plo_q[m]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cof3_q    <= cof_i;
      cof4_q    <= cof3_q;
      cof5_q    <= cof4_q;
      det_q     <= det_d;
      den_q     <= det_q[DetW-1] ? dmag_t'(-det_q) : dmag_t'(det_q);
      den_neg_q <= det_q[DetW-1];
      sing_q    <= (det_q == '0);
    end
  end

  assign cof_o     = cof5_q;
  assign den_o     = den_q;
  assign den_neg_o = den_neg_q;
  assign sing_o    = sing_q;

endmodule

[rtl/m3inv_div_lane.sv]
// One divider lane: pipelined restoring division, one quotient bit a stage.
module m3inv_div_lane import m3inv_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  cof_t      cof_i,
  input  dmag_t     den_i,
  input  logic      den_neg_i,
  output lane_res_t res_o
);

  logic [RemW-1:0]  rem_q [ElemW+1];
  logic [ElemW-1:0] lo_q  [ElemW+1];
  logic [ElemW-1:0] q_q   [ElemW+1];
  dmag_t            den_q [ElemW+1];
  logic             neg_q [ElemW+1];
  logic             sat_q [ElemW+1];
  lane_res_t        res_q;

  logic [CofW-1:0]  cmag;
  logic [NumW-1:0]  num;
  logic [RemW-1:0]  rem0;
  logic [ElemW-1:0] lim;
  logic [ElemW-1:0] qs;
  logic             over;

  assign cmag = cof_i[CofW-1] ? CofW'(-cof_i) : CofW'(cof_i);
  assign num  = {cmag, {(2*FRACTION_BITS){1'b0}}};
  assign rem0 = RemW'(num[NumW-1:ElemW]);

  // quotient fits the lane only if the high part stays below the divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem0;
      lo_q[0]  <= num[ElemW-1:0];
      q_q[0]   <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= cof_i[CofW-1] ^ den_neg_i;
      sat_q[0] <= (rem0 >= RemW'(den_i));
    end
  end

  for (genvar k = 0; k < ElemW; k++) begin : g_step
    logic [RemW-1:0] trial;
    logic            ge;
    assign trial = {rem_q[k][RemW-2:0], lo_q[k][ElemW-1]};
    assign ge    = (trial >= RemW'(den_q[k]));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? (trial - RemW'(den_q[k])) : trial;
        lo_q[k+1]  <= {lo_q[k][ElemW-2:0], 1'b0};
        q_q[k+1]   <= {q_q[k][ElemW-2:0], ge};
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
        sat_q[k+1] <= sat_q[k];
      end
    end
  end

  assign lim  = neg_q[ElemW] ? {1'b1, {(ElemW-1){1'b0}}} : {1'b0, {(ElemW-1){1'b1}}};
  assign over = sat_q[ElemW] || (q_q[ElemW] > lim);
  assign qs   = over ? lim : q_q[ElemW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.q   <= neg_q[ElemW] ? (~qs + 1'b1) : qs;
      res_q.ovf <= over;
    end
  end

  assign res_o = res_q;

endmodule

[rtl/m3inv_merge.sv]
// Merge of the lane results with singular handling, output register and skid.
module m3inv_merge import m3inv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_res_t         res_i [NumElem],
  input  logic              sing_i,
  input  logic              vld_i,
  output logic              en_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata,
  output logic [TuserW-1:0] m_axis_tuser
);

  logic [TdataW-1:0] data_d, out_data_q, skid_data_q;
  logic [TuserW-1:0] user_d, out_user_q, skid_user_q;
  logic              out_vld_q, skid_vld_q;
  logic              ovf_any;
  logic              take;

  always_comb begin
    data_d  = '0;
    ovf_any = 1'b0;
    for (int n = 0; n < NumElem; n++) begin
      data_d[n*ElemW +: ElemW] = sing_i ? '0 : res_i[n].q;
      ovf_any = ovf_any | res_i[n].ovf;
    end
    user_d = {ovf_any & ~sing_i, sing_i};
  end

  assign en_o = ~skid_vld_q;
  assign take = out_vld_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (vld_i) begin
      if (out_vld_q && !m_axis_tready) begin
        skid_vld_q <= 1'b1;
      end
      out_vld_q <= 1'b1;
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end
    end else if (vld_i) begin
      if (out_vld_q && !m_axis_tready) begin
        skid_data_q <= data_d;
        skid_user_q <= user_d;
      end else begin
        out_data_q <= data_d;
        out_user_q <= user_d;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

[rtl/matrix3x3_inverse.sv]
// Top level of the 3x3 fixed-point matrix inverse.
// Takes one row-major 3x3 matrix of signed Q16.16 elements per item and returns its
// inverse, each element truncated toward zero and saturated to Q16.16. One item is
// accepted every cycle while the pipeline is not stalled; each item passes through the
// cofactor and determinant stages and then nine divider lanes that resolve one quotient
// bit per stage. A zero determinant gives zero elements with the singular flag set.
// Backpressure stalls the whole pipeline once the output skid entry is full.
module matrix3x3_inverse import m3inv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // row0_col0, row0_col1, ..., row2_col2 (32 bits each, lowest first)
  input  logic [TdataW-1:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // inv_row0_col0, inv_row0_col1, ..., inv_row2_col2 (32 bits each, lowest first)
  output logic [TdataW-1:0] m_axis_tdata,
  // singular, overflow
  output logic [TuserW-1:0] m_axis_tuser
);

  localparam int PipeLen = FrontLat + LaneLat;

  elem_t     elem [NumElem];
  cof_t      cof_adj [NumElem];
  elem_t     row [3];
  cof_t      cof_div [NumElem];
  dmag_t     den;
  logic      den_neg;
  logic      sing;
  lane_res_t res [NumElem];
  logic      en;
  logic [PipeLen-1:0] vld_q;
  logic [LaneLat-1:0] sing_q;

  for (genvar n = 0; n < NumElem; n++) begin : g_in
    assign elem[n] = s_axis_tdata[n*ElemW +: ElemW];
  end

  assign s_axis_tready = en;

  m3inv_adj u_adj (
    .clk_i  (clk_i),
    .en_i   (en),
    .elem_i (elem),
    .cof_o  (cof_adj),
    .row_o  (row)
  );

  m3inv_det u_det (
    .clk_i     (clk_i),
    .en_i      (en),
    .cof_i     (cof_adj),
    .row_i     (row),
    .cof_o     (cof_div),
    .den_o     (den),
    .den_neg_o (den_neg),
    .sing_o    (sing)
  );

  for (genvar n = 0; n < NumElem; n++) begin : g_lane
    m3inv_div_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .cof_i     (cof_div[n]),
      .den_i     (den),
      .den_neg_i (den_neg),
      .res_o     (res[n])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeLen-2:0], s_axis_tvalid};
    end
  end

  // carry the singular flag alongside the lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q <= {sing_q[LaneLat-2:0], sing};
    end
  end

  m3inv_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .sing_i        (sing_q[LaneLat-1]),
    .vld_i         (vld_q[PipeLen-1]),
    .en_o          (en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
